FILE: src/labelled_triangle_set_match_macros.svh
// Assertion helpers shared by the RTL; each expects aclk and aresetn in scope.
`ifndef LABELLED_TRIANGLE_SET_MATCH_MACROS_SVH
`define LABELLED_TRIANGLE_SET_MATCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LTSM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LTSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/ltsm_pkg.sv
package ltsm_pkg;

    localparam int MaxQueries    = 64;
    localparam int LengthBits    = 16;
    localparam int ToleranceBits = 16;
    localparam int AddrBits      = (MaxQueries > 1) ? $clog2(MaxQueries) : 1;
    localparam int CountBits     = $clog2(MaxQueries + 1);
    localparam int CmpBits       = (LengthBits > ToleranceBits) ? LengthBits : ToleranceBits;

    typedef logic [LengthBits-1:0]    length_t;
    typedef logic [ToleranceBits-1:0] tol_t;
    typedef logic [CmpBits-1:0]       cmp_t;
    typedef logic [AddrBits-1:0]      addr_t;
    typedef logic [CountBits-1:0]     count_t;
    typedef logic [1:0]               vidx_t;

    // Item kinds
    localparam logic [1:0] KindClear  = 2'd0;
    localparam logic [1:0] KindAppend = 2'd1;
    localparam logic [1:0] KindTest   = 2'd2;

    localparam tol_t ToleranceReset = tol_t'(128);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] mol_ref;
        logic [7:0]  type_a;
        logic [7:0]  type_b;
        logic [7:0]  type_c;
        logic [15:0] dist_ab;
        logic [15:0] dist_ac;
        logic [15:0] dist_bc;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_molecule;
        logic        matched;
        logic        query_overflow;
    } out_item_t;

    // One stored query triangle, also used for the held candidate
    typedef struct packed {
        logic [7:0] type_a;
        logic [7:0] type_b;
        logic [7:0] type_c;
        length_t    len_ab;
        length_t    len_ac;
        length_t    len_bc;
    } query_t;

    localparam vidx_t PermTable [0:5][0:2] = '{
        '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2},
        '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}
    };

    // Edge slot joining two vertices: 0-1 -> 0, 0-2 -> 1, 1-2 -> 2
    function automatic vidx_t edge_slot(input vidx_t u, input vidx_t v);
        vidx_t lo;
        vidx_t hi;
        lo = (u < v) ? u : v;
        hi = (u < v) ? v : u;
        if (lo == 2'd0 && hi == 2'd1) begin
            return 2'd0;
        end else if (lo == 2'd0 && hi == 2'd2) begin
            return 2'd1;
        end
        return 2'd2;
    endfunction

endpackage

FILE: src/ltsm_ram.sv
module ltsm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
    input  logic [Width-1:0]                            wr_data,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
    output logic [Width-1:0]                            rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/ltsm_match.sv
module ltsm_match (
    input  ltsm_pkg::query_t query,
    input  ltsm_pkg::query_t cand,
    input  ltsm_pkg::tol_t   tolerance,
    output logic             match
);
    import ltsm_pkg::*;

    logic [7:0] qt [3];
    logic [7:0] ct [3];
    length_t    ql [3];
    length_t    cl [3];
    logic       teq   [3][3];
    logic       close [3][3];
    logic [5:0] perm_ok;

    assign qt = '{query.type_a, query.type_b, query.type_c};
    assign ct = '{cand.type_a, cand.type_b, cand.type_c};
    assign ql = '{query.len_ab, query.len_ac, query.len_bc};
    assign cl = '{cand.len_ab, cand.len_ac, cand.len_bc};

    // Type compares for every vertex pair and distance checks for every edge pair cover all permutations
    always_comb begin
        length_t diff;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                teq[i][j]   = (qt[i] == ct[j]);
                diff        = (ql[i] >= cl[j]) ? (ql[i] - cl[j]) : (cl[j] - ql[i]);
                close[i][j] = (cmp_t'(diff) <= cmp_t'(tolerance));
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            perm_ok[k] = teq[0][PermTable[k][0]] && teq[1][PermTable[k][1]]
                && teq[2][PermTable[k][2]]
                && close[0][edge_slot(PermTable[k][0], PermTable[k][1])]
                && close[1][edge_slot(PermTable[k][0], PermTable[k][2])]
                && close[2][edge_slot(PermTable[k][1], PermTable[k][2])];
        end
    end

    assign match = |perm_ok;

endmodule

FILE: src/labelled_triangle_set_match.sv
// Channel  Ports                              Moves
// -------  ---------------------------------  ---------------------------------
// input    s_valid, s_ready, s_item           one clear, append or test item
// output   m_valid, m_ready, m_item           one result item per test item
// config   cfg_valid, cfg_ready, cfg_data     match tolerance, Q8.8
//
// Clear and append items complete in the idle state. A test item latches the candidate
// and walks the stored queries up to and including the first hit (at most the stored
// count), one query a cycle from the single store read port, then waits for the output
// register to be free. A test on an empty set skips the walk. Synchronous active-low
// reset empties the set and restores the tolerance; no clearing pass runs. A stalled
// result holds in the output register while the block takes the next item.
`include "labelled_triangle_set_match_macros.svh"

module labelled_triangle_set_match (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ltsm_pkg::in_item_t    s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ltsm_pkg::out_item_t   m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data
);
    import ltsm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t      state_reg, state_next;
    count_t      count_reg, count_next;
    logic        overflow_reg, overflow_next;
    tol_t        tolerance_reg;
    addr_t       q_reg, q_next;
    logic        hit_reg, hit_next;
    query_t      cand_reg, cand_next;
    logic [31:0] mol_reg, mol_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_item_reg, m_item_next;

    query_t      in_query;
    query_t      rd_query;
    logic        wr_en;
    addr_t       rd_addr;
    logic        q_match;
    logic        q_last;

    // Pack the incoming triangle; lengths keep LengthBits bits
    assign in_query = '{
        type_a: s_item.type_a,
        type_b: s_item.type_b,
        type_c: s_item.type_c,
        len_ab: length_t'(s_item.dist_ab),
        len_ac: length_t'(s_item.dist_ac),
        len_bc: length_t'(s_item.dist_bc)
    };

    ltsm_ram #(
        .Width ($bits(query_t)),
        .Depth (MaxQueries)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AddrBits-1:0]),
        .wr_data (in_query),
        .rd_addr (rd_addr),
        .rd_data (rd_query)
    );

    // Shared compare unit: one stored query against the held candidate
    ltsm_match u_match (
        .query     (rd_query),
        .cand      (cand_reg),
        .tolerance (tolerance_reg),
        .match     (q_match)
    );

    assign q_last    = ((count_t'(q_reg) + count_t'(1)) == count_reg);
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // Prefetch the next query while the current one is compared
    assign rd_addr = (state_reg == ST_SCAN) ? addr_t'(q_reg + addr_t'(1)) : '0;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        q_next        = q_reg;
        hit_next      = hit_reg;
        cand_next     = cand_reg;
        mol_next      = mol_reg;
        m_item_next   = m_item_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        wr_en         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_item.kind)
                        KindClear: begin
                            count_next    = '0;
                            overflow_next = 1'b0;
                        end
                        KindAppend: begin
                            if (count_reg < count_t'(MaxQueries)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + count_t'(1);
                            end else begin
                                overflow_next = 1'b1;
                            end
                        end
                        KindTest: begin
                            cand_next = in_query;
                            mol_next  = s_item.mol_ref;
                            q_next    = '0;
                            if (count_reg == '0) begin
                                hit_next   = 1'b0;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            // unused kind: drop
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (q_match || q_last) begin
                    hit_next   = q_match;
                    state_next = ST_DONE;
                end else begin
                    q_next = q_reg + addr_t'(1);
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{
                        result_molecule: mol_reg,
                        matched:         hit_reg,
                        query_overflow:  overflow_reg
                    };
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
        q_reg      <= q_next;
        hit_reg    <= hit_next;
        cand_reg   <= cand_next;
        mol_reg    <= mol_next;
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= ToleranceReset;
        end else if (cfg_valid && cfg_ready) begin
            tolerance_reg <= tol_t'(cfg_data);
        end
    end

    `LTSM_ASSERT_IMPL(a_count_range, 1'b1, count_reg <= count_t'(MaxQueries))
    `LTSM_ASSERT_IMPL(a_scan_in_set, state_reg == ST_SCAN, count_t'(q_reg) < count_reg)
    `LTSM_ASSERT_NEXT(a_empty_miss,
        s_valid && s_ready && s_item.kind == KindTest && count_reg == '0,
        state_reg == ST_DONE && !hit_reg)
    `LTSM_ASSERT_NEXT(a_full_overflow,
        s_valid && s_ready && s_item.kind == KindAppend && count_reg == count_t'(MaxQueries),
        overflow_reg && count_reg == count_t'(MaxQueries))

endmodule
